/* design/jrpm_pkg.sv */
// Shared constants, codes and types for the Jaro record-pair matcher.
package jrpm_pkg;

  localparam int MAX_CHARS = 256;
  localparam int FIELDS = 4;
  localparam int FIELD_W = 2;
  localparam int CHAR_W = 8;
  localparam int CHAR_AW = $clog2(MAX_CHARS);
  localparam int LEN_W = CHAR_AW + 1;
  localparam int REC_AW = FIELD_W + CHAR_AW;
  localparam int REC_DEPTH = FIELDS * MAX_CHARS;
  localparam int SCORE_W = 17;
  localparam int CFG_IDX_W = 2;
  localparam int ACTION_W = 2;

  // Widths of the exact similarity fraction terms.
  localparam int MM_W = 2 * LEN_W;
  localparam int SUM_W = LEN_W + 1;
  localparam int M6_W = LEN_W + 3;
  localparam int NUM_W = 3 * LEN_W + 3;
  localparam int DIV_CNT_W = $clog2(SCORE_W);

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD_FIRST  = 2'd0,
    ACT_LOAD_SECOND = 2'd1,
    ACT_EVALUATE    = 2'd2
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NAME_THR    = 2'd0,
    REG_ADDRESS_THR = 2'd1,
    REG_CITY_THR    = 2'd2,
    REG_KIND_THR    = 2'd3
  } cfg_reg_t;

  typedef logic [SCORE_W-1:0] score_t;
  typedef logic [LEN_W-1:0] len_t;

  localparam score_t THR_RESET [FIELDS] = '{
    score_t'(62259), score_t'(35389), score_t'(50463), score_t'(0)
  };

endpackage

/* design/jrpm_channels.sv */
// Input and result channel interfaces of the Jaro record-pair matcher.
interface jrpm_in_if import jrpm_pkg::*;;
  logic valid;
  logic ready;
  logic [ACTION_W-1:0] action;
  logic [FIELD_W-1:0] field_sel;
  logic [CHAR_W-1:0] char_code;

  modport source(output valid, action, field_sel, char_code, input ready);
  modport sink(input valid, action, field_sel, char_code, output ready);
endinterface

interface jrpm_out_if import jrpm_pkg::*;;
  logic valid;
  logic ready;
  logic [SCORE_W-1:0] name_score;
  logic [SCORE_W-1:0] address_score;
  logic [SCORE_W-1:0] city_score;
  logic [SCORE_W-1:0] kind_score;
  logic is_duplicate;
  logic overflow;

  modport source(output valid, name_score, address_score, city_score, kind_score,
                 is_duplicate, overflow, input ready);
  modport sink(input valid, name_score, address_score, city_score, kind_score,
               is_duplicate, overflow, output ready);
endinterface

/* design/jaro_record_pair_matcher_unit.sv */
// Top level of the Jaro record-pair matcher.
// Usage: characters of four text fields (name, address, city, type) of two
// records stream in on in_ch, one transaction per cycle while idle; action 0
// appends to the first record, action 1 to the second. Appends give no result.
// An append to a full field (256 characters) is dropped and
// raises the overflow flag of the next result. Action 2 evaluates the pair:
// in_ch stalls while each field's Jaro similarity is computed, and one
// result transaction with four Q1.16 scores, the duplicate flag and the
// overflow flag appears on out_ch. Both records and the flag are then clear.
// Evaluate time per field is set by the match walk through the character and
// mark memories, then the multiply states S_MUL1 to S_MUL3 and the divider.
// An empty field skips the walk, the multiplies and the divider.
// The result waits in an output register; if out_ch stalls, the block holds
// the next evaluate at its end until the register is taken. Synchronous reset
// restores the thresholds and empties both records; no memory clearing pass.
// Configuration writes (cfg_write, cfg_index, cfg_data) are registered into the thresholds.
module jaro_record_pair_matcher_unit import jrpm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SCORE_W-1:0]   cfg_data,
  jrpm_in_if.sink              in_ch,
  jrpm_out_if.source           out_ch
);

  typedef enum logic [4:0] {
    S_IDLE, S_SETUP, S_CLEAR, S_AREAD, S_JREAD, S_JCHECK, S_TREAD, S_TCHECK,
    S_KREAD, S_KCHECK, S_MUL1, S_MUL2, S_MUL3, S_DIV, S_DIVWAIT, S_NEXT, S_DONE
  } state_t;

  state_t state;
  score_t thr [FIELDS];
  score_t score_r [FIELDS];
  len_t len_a [FIELDS];
  len_t len_b [FIELDS];
  logic overflow_seen;

  logic [FIELD_W-1:0] f;
  len_t la, lb, win, i, j, k, hi, m, h;
  logic [CHAR_W-1:0] a_rd, b_rd;
  logic mark_rd, hit_rd;

  logic [MM_W-1:0] mm, lalb;
  logic [SUM_W-1:0] sum_len, d2;
  logic [M6_W-1:0] m6;
  logic [NUM_W-1:0] p1, p2, num, den;
  logic div_done;
  score_t quot;

  // Input side.
  logic acc;
  logic [FIELD_W-1:0] len_idx;
  len_t cur_len_a, cur_len_b;
  logic load_a, load_b, full_a, full_b;

  assign in_ch.ready = (state == S_IDLE);
  assign acc = in_ch.valid && in_ch.ready;
  assign len_idx = (state == S_IDLE) ? in_ch.field_sel : f;
  assign cur_len_a = len_a[len_idx];
  assign cur_len_b = len_b[len_idx];
  assign full_a = (cur_len_a == len_t'(MAX_CHARS));
  assign full_b = (cur_len_b == len_t'(MAX_CHARS));
  assign load_a = acc && (in_ch.action == ACT_LOAD_FIRST);
  assign load_b = acc && (in_ch.action == ACT_LOAD_SECOND);

  // Window bounds for the current first-string position.
  logic [LEN_W:0] i_plus_w;
  len_t lb_m1, lo, hi_c, longer, half;
  logic win_empty, last_i;
  always_comb begin
    longer = (cur_len_a > cur_len_b) ? cur_len_a : cur_len_b;
    half = longer >> 1;
    lb_m1 = lb - 1'b1;
    lo = (i > win) ? (i - win) : '0;
    i_plus_w = {1'b0, i} + {1'b0, win};
    hi_c = (i_plus_w > {1'b0, lb_m1}) ? lb_m1 : i_plus_w[LEN_W-1:0];
    win_empty = (lo > hi_c);
    last_i = ((i + 1'b1) == la);
  end

  // Memory ports.
  logic a_we, b_we, mark_we, mark_wd, hit_we, hit_wd;
  logic [REC_AW-1:0] a_waddr, b_waddr, a_raddr, b_raddr;
  logic [CHAR_AW-1:0] mark_waddr, mark_raddr;
  logic matched;
  logic use_k;

  always_comb begin
    use_k = (state == S_KREAD);
    matched = !mark_rd && (b_rd == a_rd);
    a_we = load_a && !full_a;
    b_we = load_b && !full_b;
    a_waddr = {in_ch.field_sel, cur_len_a[CHAR_AW-1:0]};
    b_waddr = {in_ch.field_sel, cur_len_b[CHAR_AW-1:0]};
    a_raddr = {f, i[CHAR_AW-1:0]};
    b_raddr = {f, use_k ? k[CHAR_AW-1:0] : j[CHAR_AW-1:0]};
    mark_raddr = use_k ? k[CHAR_AW-1:0] : j[CHAR_AW-1:0];
    mark_we = 1'b0;
    mark_wd = 1'b0;
    mark_waddr = j[CHAR_AW-1:0];
    hit_we = 1'b0;
    hit_wd = 1'b0;
    case (state)
      S_CLEAR: begin
        mark_we = 1'b1;
        mark_waddr = k[CHAR_AW-1:0];
      end
      S_AREAD: begin
        hit_we = win_empty;
      end
      S_JCHECK: begin
        mark_we = matched;
        mark_wd = 1'b1;
        hit_we = matched || (j == hi);
        hit_wd = matched;
      end
      default: begin
      end
    endcase
  end

  jrpm_ram #(.WIDTH(CHAR_W), .DEPTH(REC_DEPTH)) u_first_chars (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(in_ch.char_code),
    .raddr(a_raddr), .rdata(a_rd)
  );

  jrpm_ram #(.WIDTH(CHAR_W), .DEPTH(REC_DEPTH)) u_second_chars (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(in_ch.char_code),
    .raddr(b_raddr), .rdata(b_rd)
  );

  jrpm_ram #(.WIDTH(1), .DEPTH(MAX_CHARS)) u_marks (
    .clk(clk), .we(mark_we), .waddr(mark_waddr), .wdata(mark_wd),
    .raddr(mark_raddr), .rdata(mark_rd)
  );

  jrpm_ram #(.WIDTH(1), .DEPTH(MAX_CHARS)) u_hits (
    .clk(clk), .we(hit_we), .waddr(i[CHAR_AW-1:0]), .wdata(hit_wd),
    .raddr(i[CHAR_AW-1:0]), .rdata(hit_rd)
  );

  jrpm_div u_div (
    .clk(clk), .rst(rst), .start(state == S_DIV), .num(num), .den(den),
    .done(div_done), .quot(quot)
  );

  logic dup;
  always_comb begin
    dup = 1'b1;
    for (int g = 0; g < FIELDS; g++) begin
      if (score_r[g] < thr[g]) begin
        dup = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_ch.valid <= 1'b0;
      overflow_seen <= 1'b0;
      f <= '0;
      for (int g = 0; g < FIELDS; g++) begin
        thr[g] <= THR_RESET[g];
        len_a[g] <= '0;
        len_b[g] <= '0;
      end
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_NAME_THR:    thr[0] <= cfg_data;
          REG_ADDRESS_THR: thr[1] <= cfg_data;
          REG_CITY_THR:    thr[2] <= cfg_data;
          REG_KIND_THR:    thr[3] <= cfg_data;
          default: begin
          end
        endcase
      end
      case (state)
        S_IDLE: begin
          if (load_a) begin
            if (full_a) overflow_seen <= 1'b1;
            else len_a[in_ch.field_sel] <= cur_len_a + 1'b1;
          end
          if (load_b) begin
            if (full_b) overflow_seen <= 1'b1;
            else len_b[in_ch.field_sel] <= cur_len_b + 1'b1;
          end
          if (acc && in_ch.action == ACT_EVALUATE) begin
            f <= '0;
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          la <= cur_len_a;
          lb <= cur_len_b;
          win <= (half != '0) ? (half - 1'b1) : '0;
          k <= '0;
          if (cur_len_a == '0 || cur_len_b == '0) begin
            score_r[f] <= '0;
            state <= S_NEXT;
          end else begin
            state <= S_CLEAR;
          end
        end
        S_CLEAR: begin
          if (k == lb_m1) begin
            i <= '0;
            m <= '0;
            state <= S_AREAD;
          end else begin
            k <= k + 1'b1;
          end
        end
        S_AREAD: begin
          j <= lo;
          hi <= hi_c;
          if (!win_empty) begin
            state <= S_JREAD;
          end else if (!last_i) begin
            i <= i + 1'b1;
          end else if (m == '0) begin
            score_r[f] <= '0;
            state <= S_NEXT;
          end else begin
            i <= '0;
            k <= '0;
            h <= '0;
            state <= S_TREAD;
          end
        end
        S_JREAD: begin
          state <= S_JCHECK;
        end
        S_JCHECK: begin
          if (matched) begin
            m <= m + 1'b1;
          end
          if (!matched && j != hi) begin
            j <= j + 1'b1;
            state <= S_JREAD;
          end else if (!last_i) begin
            i <= i + 1'b1;
            state <= S_AREAD;
          end else if (!matched && m == '0) begin
            score_r[f] <= '0;
            state <= S_NEXT;
          end else begin
            i <= '0;
            k <= '0;
            h <= '0;
            state <= S_TREAD;
          end
        end
        S_TREAD: begin
          state <= S_TCHECK;
        end
        S_TCHECK: begin
          if (hit_rd && k < lb) begin
            state <= S_KREAD;
          end else if (last_i) begin
            state <= S_MUL1;
          end else begin
            i <= i + 1'b1;
            state <= S_TREAD;
          end
        end
        S_KREAD: begin
          state <= S_KCHECK;
        end
        S_KCHECK: begin
          k <= k + 1'b1;
          if (mark_rd && a_rd != b_rd) begin
            h <= h + 1'b1;
          end
          // Skip unmatched second-string characters until a matched one.
          if (!mark_rd && (k + 1'b1) < lb) begin
            state <= S_KREAD;
          end else if (last_i) begin
            state <= S_MUL1;
          end else begin
            i <= i + 1'b1;
            state <= S_TREAD;
          end
        end
        S_MUL1: begin
          mm <= MM_W'(m) * MM_W'(m);
          lalb <= MM_W'(la) * MM_W'(lb);
          sum_len <= SUM_W'(la) + SUM_W'(lb);
          d2 <= {m, 1'b0} - SUM_W'(h);
          m6 <= M6_W'(m) * M6_W'(6);
          state <= S_MUL2;
        end
        S_MUL2: begin
          p1 <= NUM_W'(mm) * NUM_W'(sum_len);
          p2 <= NUM_W'(d2) * NUM_W'(lalb);
          den <= NUM_W'(m6) * NUM_W'(lalb);
          state <= S_MUL3;
        end
        S_MUL3: begin
          num <= {p1[NUM_W-2:0], 1'b0} + p2;
          state <= S_DIV;
        end
        S_DIV: begin
          state <= S_DIVWAIT;
        end
        S_DIVWAIT: begin
          if (div_done) begin
            score_r[f] <= quot;
            state <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (f == FIELD_W'(FIELDS - 1)) begin
            state <= S_DONE;
          end else begin
            f <= f + 1'b1;
            state <= S_SETUP;
          end
        end
        S_DONE: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid <= 1'b1;
            out_ch.name_score <= score_r[0];
            out_ch.address_score <= score_r[1];
            out_ch.city_score <= score_r[2];
            out_ch.kind_score <= score_r[3];
            out_ch.is_duplicate <= dup;
            out_ch.overflow <= overflow_seen;
            overflow_seen <= 1'b0;
            for (int g = 0; g < FIELDS; g++) begin
              len_a[g] <= '0;
              len_b[g] <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* design/jrpm_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module jrpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/jrpm_div.sv */
// Restoring divider giving floor(num * 2^16 / den) one quotient bit per cycle.
module jrpm_div import jrpm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [NUM_W-1:0] den,
  output logic             done,
  output score_t           quot
);

  logic [NUM_W:0] rem;
  logic [NUM_W:0] trial;
  logic [DIV_CNT_W-1:0] cnt;
  logic busy;
  logic ge;

  // The first step weighs 2^16 directly; later steps shift the remainder.
  always_comb begin
    trial = (cnt == '0) ? rem : {rem[NUM_W-1:0], 1'b0};
    ge = (trial >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
        rem <= {1'b0, num};
        quot <= '0;
      end else if (busy) begin
        rem <= ge ? (trial - {1'b0, den}) : trial;
        quot <= {quot[SCORE_W-2:0], ge};
        if (cnt == DIV_CNT_W'(SCORE_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

endmodule

/* design/jrpm_checker.sv */
// Port-level checker for the Jaro record-pair matcher and its bind.
module jrpm_checker import jrpm_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic [ACTION_W-1:0] in_action,
  input logic             out_valid,
  input logic             out_ready,
  input logic [SCORE_W-1:0] name_score,
  input logic [SCORE_W-1:0] address_score,
  input logic [SCORE_W-1:0] city_score,
  input logic [SCORE_W-1:0] kind_score
);

  localparam logic [SCORE_W-1:0] ONE_Q16 = SCORE_W'(65536);

  // A result transaction is held until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  // An evaluate transaction stalls the input while the pair is scored.
  a_eval_stalls: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_action == ACT_EVALUATE |=> !in_ready)
    else $error("input accepted during evaluation");

  // A new result only comes out of an evaluation, never from the idle input.
  a_result_from_eval: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without an evaluation");

  // Similarities never exceed one.
  a_score_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> name_score <= ONE_Q16 && address_score <= ONE_Q16 &&
                  city_score <= ONE_Q16 && kind_score <= ONE_Q16)
    else $error("score above one");

endmodule

bind jaro_record_pair_matcher_unit jrpm_checker u_jrpm_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(in_ch.valid),
  .in_ready(in_ch.ready),
  .in_action(in_ch.action),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .name_score(out_ch.name_score),
  .address_score(out_ch.address_score),
  .city_score(out_ch.city_score),
  .kind_score(out_ch.kind_score)
);

/* bench/jrpm_match_checker.sv */
// Scoreboard for the Jaro record-pair matcher: tracks both records, predicts scores, compares.
`timescale 1ns / 100ps
module jrpm_match_checker import jrpm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SCORE_W-1:0]   cfg_data,
  jrpm_in_if                   in_ch,
  jrpm_out_if                  out_ch,
  output int                   mismatches,
  output int                   outstanding,
  output int                   evaluations
);

  typedef struct packed {
    score_t name_score;
    score_t address_score;
    score_t city_score;
    score_t kind_score;
    logic   is_duplicate;
    logic   overflow;
  } pair_verdict_t;

  logic [CHAR_W-1:0] first_chars [FIELDS][MAX_CHARS];
  logic [CHAR_W-1:0] second_chars [FIELDS][MAX_CHARS];
  int     first_len [FIELDS];
  int     second_len [FIELDS];
  logic   dropped_char;
  score_t thresholds [FIELDS];
  pair_verdict_t expected_verdicts [$];

  initial begin
    mismatches = 0;
    outstanding = 0;
    evaluations = 0;
  end

  function automatic score_t jaro_score(int f);
    int la, lb, longer, win, lo, hi, m, h, k;
    bit hit_first [MAX_CHARS];
    bit hit_second [MAX_CHARS];
    longint unsigned num, den;
    la = first_len[f];
    lb = second_len[f];
    if (la == 0 || lb == 0) return '0;
    for (int i = 0; i < MAX_CHARS; i++) begin
      hit_first[i] = 0;
      hit_second[i] = 0;
    end
    longer = (la > lb) ? la : lb;
    win = (longer / 2 >= 1) ? longer / 2 - 1 : 0;
    m = 0;
    for (int i = 0; i < la; i++) begin
      lo = (i > win) ? i - win : 0;
      hi = (i + win > lb - 1) ? lb - 1 : i + win;
      for (int j = lo; j <= hi; j++) begin
        if (!hit_second[j] && second_chars[f][j] == first_chars[f][i]) begin
          hit_second[j] = 1;
          hit_first[i] = 1;
          m++;
          break;
        end
      end
    end
    if (m == 0) return '0;
    h = 0;
    k = 0;
    for (int i = 0; i < la; i++) begin
      if (hit_first[i]) begin
        while (k < lb && !hit_second[k]) k++;
        if (k < lb) begin
          if (first_chars[f][i] != second_chars[f][k]) h++;
          k++;
        end
      end
    end
    num = 64'(2 * m * m) * 64'(lb) + 64'(2 * m * m) * 64'(la)
        + 64'(2 * m - h) * 64'(la) * 64'(lb);
    den = 64'(6 * m) * 64'(la) * 64'(lb);
    return score_t'((num * 64'd65536) / den);
  endfunction

  task automatic report(string what, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    pair_verdict_t v;
    score_t s [FIELDS];
    if (rst) begin
      for (int f = 0; f < FIELDS; f++) begin
        first_len[f] = 0;
        second_len[f] = 0;
        thresholds[f] = THR_RESET[f];
      end
      dropped_char = 0;
      expected_verdicts.delete();
    end else begin
      if (cfg_write) thresholds[cfg_index] = cfg_data;

      if (out_ch.valid && out_ch.ready) begin
        if (expected_verdicts.size() == 0) begin
          report("unexpected result transaction", 1, 0);
        end else begin
          v = expected_verdicts.pop_front();
          if (out_ch.name_score !== v.name_score)
            report("name_score", out_ch.name_score, v.name_score);
          if (out_ch.address_score !== v.address_score)
            report("address_score", out_ch.address_score, v.address_score);
          if (out_ch.city_score !== v.city_score)
            report("city_score", out_ch.city_score, v.city_score);
          if (out_ch.kind_score !== v.kind_score)
            report("kind_score", out_ch.kind_score, v.kind_score);
          if (out_ch.is_duplicate !== v.is_duplicate)
            report("is_duplicate", out_ch.is_duplicate, v.is_duplicate);
          if (out_ch.overflow !== v.overflow)
            report("overflow", out_ch.overflow, v.overflow);
        end
      end

      if (in_ch.valid && in_ch.ready) begin
        case (in_ch.action)
          ACT_LOAD_FIRST: begin
            if (first_len[in_ch.field_sel] >= MAX_CHARS) dropped_char = 1;
            else begin
              first_chars[in_ch.field_sel][first_len[in_ch.field_sel]] = in_ch.char_code;
              first_len[in_ch.field_sel]++;
            end
          end
          ACT_LOAD_SECOND: begin
            if (second_len[in_ch.field_sel] >= MAX_CHARS) dropped_char = 1;
            else begin
              second_chars[in_ch.field_sel][second_len[in_ch.field_sel]] = in_ch.char_code;
              second_len[in_ch.field_sel]++;
            end
          end
          ACT_EVALUATE: begin
            v.is_duplicate = 1;
            for (int f = 0; f < FIELDS; f++) begin
              s[f] = jaro_score(f);
              if (s[f] < thresholds[f]) v.is_duplicate = 0;
              first_len[f] = 0;
              second_len[f] = 0;
            end
            v.name_score = s[0];
            v.address_score = s[1];
            v.city_score = s[2];
            v.kind_score = s[3];
            v.overflow = dropped_char;
            dropped_char = 0;
            expected_verdicts.push_back(v);
            evaluations++;
          end
          default: ;
        endcase
      end
      outstanding = expected_verdicts.size();
    end
  end

endmodule

/* bench/testbench.sv */
// Top of the matcher testbench: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 100ps
module testbench import jrpm_pkg::*;;

  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam int ITEM_GOAL = 1950;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int HOLD_CYCLES = 3000;

  logic clk;
  logic rst;
  logic cfg_write;
  cfg_reg_t cfg_index;
  score_t cfg_data;

  jrpm_in_if in_ch();
  jrpm_out_if out_ch();

  int mismatches, outstanding, evaluations;
  int tx_idle_pct, rx_idle_pct;
  int hold_requests, hold_seen, hold_left;
  int cycles, load_items;

  jaro_record_pair_matcher_unit u_dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  jrpm_match_checker u_checker (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch),
    .mismatches(mismatches), .outstanding(outstanding), .evaluations(evaluations)
  );

  initial clk = 0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off when the stimulus asks for one.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 0;
    end else begin
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic send(logic [ACTION_W-1:0] act, int field, logic [CHAR_W-1:0] ch);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.action <= act;
    in_ch.field_sel <= field[FIELD_W-1:0];
    in_ch.char_code <= ch;
    do @(posedge clk); while (!in_ch.ready);
    if (act != ACT_UNUSED) load_items++;
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_thresholds(score_t n, score_t a, score_t c, score_t k);
    cfg_write <= 1;
    cfg_index <= REG_NAME_THR;    cfg_data <= n; @(posedge clk);
    cfg_index <= REG_ADDRESS_THR; cfg_data <= a; @(posedge clk);
    cfg_index <= REG_CITY_THR;    cfg_data <= c; @(posedge clk);
    cfg_index <= REG_KIND_THR;    cfg_data <= k; @(posedge clk);
    cfg_write <= 0;
  endtask

  task automatic load_text(logic [ACTION_W-1:0] act, int field, string s);
    for (int i = 0; i < s.len(); i++) send(act, field, s[i]);
  endtask

  function automatic score_t pick_threshold();
    case ($urandom_range(5))
      0: return '0;
      1: return score_t'(65536);
      2: return score_t'(131071);
      default: return score_t'($urandom_range(65536));
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] pick_char(bit narrow);
    return narrow ? CHAR_W'(8'h61 + $urandom_range(3)) : CHAR_W'($urandom_range(255));
  endfunction

  // One record pair with random content, loaded in shuffled order, then evaluated.
  task automatic random_pair();
    logic [CHAR_W-1:0] text [2*FIELDS][$];
    logic [CHAR_W-1:0] tmp;
    int la, lb, slot, pos;
    bit narrow;
    for (int f = 0; f < FIELDS; f++) begin
      narrow = ($urandom_range(9) < 7);
      la = ($urandom_range(9) < 8) ? $urandom_range(8) : $urandom_range(9, 24);
      for (int i = 0; i < la; i++) text[f].push_back(pick_char(narrow));
      if ($urandom_range(1)) begin
        text[FIELDS + f] = text[f];
        case ($urandom_range(3))
          0: if (text[f].size() > 1) begin
            pos = $urandom_range(text[f].size() - 2);
            tmp = text[FIELDS + f][pos];
            text[FIELDS + f][pos] = text[FIELDS + f][pos + 1];
            text[FIELDS + f][pos + 1] = tmp;
          end
          1: if (text[f].size() > 0)
            text[FIELDS + f][$urandom_range(text[f].size() - 1)] = pick_char(narrow);
          2: if (text[f].size() > 0)
            text[FIELDS + f].delete($urandom_range(text[f].size() - 1));
          default: ;
        endcase
      end else begin
        lb = ($urandom_range(9) < 8) ? $urandom_range(8) : $urandom_range(9, 24);
        for (int i = 0; i < lb; i++) text[FIELDS + f].push_back(pick_char(narrow));
      end
    end
    forever begin
      slot = -1;
      for (int t = 0; t < 8 && slot < 0; t++) begin
        pos = $urandom_range(2 * FIELDS - 1);
        if (text[pos].size() > 0) slot = pos;
      end
      for (int s = 0; s < 2 * FIELDS && slot < 0; s++) if (text[s].size() > 0) slot = s;
      if (slot < 0) break;
      if ($urandom_range(99) < 3)
        send(ACT_UNUSED, $urandom_range(3), CHAR_W'($urandom_range(255)));
      send(slot < FIELDS ? ACT_LOAD_FIRST : ACT_LOAD_SECOND, slot % FIELDS,
           text[slot].pop_front());
    end
    send(ACT_EVALUATE, $urandom_range(3), CHAR_W'($urandom_range(255)));
  endtask

  initial begin
    rst = 1;
    cfg_write = 0;
    cfg_index = REG_NAME_THR;
    cfg_data = '0;
    in_ch.valid <= 0;
    in_ch.action <= ACT_LOAD_FIRST;
    in_ch.field_sel <= '0;
    in_ch.char_code <= '0;
    tx_idle_pct = 14;
    rx_idle_pct = 81;
    hold_requests = 0;
    hold_seen = 0;
    hold_left = 0;
    cycles = 0;
    load_items = 0;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: all fields empty, single equal characters, byte extremes,
    // classic transposition strings, unused action, one side empty.
    send(ACT_EVALUATE, 0, 8'hFF);
    send(ACT_LOAD_FIRST, 0, 8'h00);
    send(ACT_LOAD_SECOND, 0, 8'h00);
    send(ACT_LOAD_FIRST, 3, 8'hFF);
    send(ACT_LOAD_SECOND, 3, 8'hFF);
    send(ACT_EVALUATE, 3, 8'h00);
    send(ACT_LOAD_FIRST, 0, 8'h00);
    send(ACT_LOAD_FIRST, 0, 8'hFF);
    send(ACT_LOAD_SECOND, 0, 8'hFF);
    send(ACT_LOAD_SECOND, 0, 8'h00);
    load_text(ACT_LOAD_FIRST, 1, "MARTHA");
    load_text(ACT_LOAD_SECOND, 1, "MARHTA");
    send(ACT_UNUSED, 3, 8'hFF);
    load_text(ACT_LOAD_FIRST, 2, "DIXON");
    load_text(ACT_LOAD_SECOND, 2, "DICKSONX");
    load_text(ACT_LOAD_FIRST, 3, "ab");
    send(ACT_EVALUATE, 1, 8'h55);
    // A field filled past its capacity drops the extra character.
    for (int i = 0; i <= MAX_CHARS; i++) send(ACT_LOAD_FIRST, 3, CHAR_W'($urandom_range(255)));
    send(ACT_LOAD_SECOND, 0, 8'h41);
    send(ACT_EVALUATE, 2, 8'hAA);
    drain();

    for (int seg = 0; seg < 4; seg++) begin
      case (seg)
        0: write_thresholds('0, '0, '0, '0);
        1: write_thresholds(pick_threshold(), pick_threshold(), pick_threshold(),
                            pick_threshold());
        2: write_thresholds(score_t'(65536), score_t'(131071), score_t'(65536), '0);
        default: write_thresholds(score_t'(40000), score_t'(30000), score_t'(45000), '0);
      endcase
      tx_idle_pct = (seg < 2) ? 14 : (seg == 2) ? 81 : 0;
      rx_idle_pct = (seg < 2) ? 81 : (seg == 2) ? 14 : 0;
      if (seg == 2) begin
        // Receiver holds off while several evaluations queue up behind it.
        hold_requests++;
        repeat (8) random_pair();
        drain();
      end
      while (load_items < ITEM_GOAL * (seg + 1) / 4) random_pair();
      drain();
    end

    repeat (200) @(posedge clk);
    $display("Ran %0d load and evaluate transactions, %0d pair evaluations,", load_items,
             evaluations);
    $display("under four threshold settings, mixed stalls and a long result hold-off.");
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
